@@ sv/brar_pkg.sv @@
// ----------------------------------------------------------------------------
// brar_pkg
// Shared constants and the CORDIC arctangent table for the bisection root
// finder and mean value block.
// ----------------------------------------------------------------------------
package brar_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 32;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;

  localparam logic [31:0] TOL_RESET   = 32'd1;
  localparam logic [7:0]  MAXIT_RESET = 8'd100;

  // register indexes
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_MAX_ITER  = 1'b1;

  // status codes
  localparam logic [1:0] ST_ENDPOINT  = 2'd0;
  localparam logic [1:0] ST_CONVERGED = 2'd1;
  localparam logic [1:0] ST_ITER_LIM  = 2'd2;
  localparam logic [1:0] ST_ZERO_ROOT = 2'd3;

  // atan(2^-i) in Q30, truncated; exact 2^(30-i)-1 from step 11 on
  function automatic logic [31:0] atan_q30(input logic [5:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        6'd0:    r = 32'd843314856;
        6'd1:    r = 32'd497837829;
        6'd2:    r = 32'd263043836;
        6'd3:    r = 32'd133525158;
        6'd4:    r = 32'd67021686;
        6'd5:    r = 32'd33543515;
        6'd6:    r = 32'd16775850;
        6'd7:    r = 32'd8388437;
        6'd8:    r = 32'd4194282;
        6'd9:    r = 32'd2097149;
        6'd10:   r = 32'd1048575;
        default: r = (i <= 6'd30) ? ((32'd1 << (6'd30 - i)) - 32'd1) : 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/bisection_root_and_average.sv @@
// Work is sequenced through the shared CORDIC rotator and multiplier and the restoring
// divider; a zero root ends the search early, without the mean value step.
// busy is high for the whole item, and a new item is taken only once the last is done.
// done pulses for one cycle with the result; the receiver cannot stall.
// Synchronous active-high reset: idle, tolerance 1, max_iterations 100.
// ----------------------------------------------------------------------------
// bisection_root_and_average
// Finds the zero of cos(x) + a*x*sin(x) on [0,pi] by bisection with a shared
// CORDIC and multiplier, then divides out the mean of f over [0,x0].
// ----------------------------------------------------------------------------
module bisection_root_and_average #(
  parameter int unsigned CORDIC_STEPS = brar_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] a_value,
  output logic        done,
  output logic [31:0] root,
  output logic signed [31:0] average,
  output logic [1:0]  status,
  input  logic        write_enable,
  input  logic        write_index,
  input  logic [31:0] write_data
);
  import brar_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_ROT    = 4'd2;
  localparam logic [3:0] S_MUL_AX = 4'd3;
  localparam logic [3:0] S_MUL_HI = 4'd4;
  localparam logic [3:0] S_MUL_LO = 4'd5;
  localparam logic [3:0] S_FDONE  = 4'd6;
  localparam logic [3:0] S_STEP   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;
  localparam logic [3:0] S_T1     = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_SAT    = 4'd11;

  localparam logic [2:0] PH_F0   = 3'd0;
  localparam logic [2:0] PH_FPI  = 3'd1;
  localparam logic [2:0] PH_FMID = 3'd2;
  localparam logic [2:0] PH_AVG  = 3'd3;

  logic [3:0]  state;
  logic [2:0]  phase;
  logic [31:0] tolerance;
  logic [7:0]  max_iterations;
  logic [23:0] a_reg;
  logic [31:0] arg;
  logic [31:0] interval_low, interval_high, midpoint, half;
  logic [7:0]  step_count;
  logic        low_pos, low_neg;
  logic [31:0] root_r;
  logic [1:0]  status_r;

  logic signed [33:0] cx, cy, cz;
  logic        flip;
  logic [CW-1:0] ci;

  logic [39:0] ax;
  logic [53:0] hm;
  logic signed [45:0] mq;
  logic        ineg;
  logic [63:0] num;
  logic [32:0] rem;
  logic [5:0]  dcnt;

  // shared multiplier
  logic signed [33:0] ma, mb;
  logic signed [67:0] mul_p;

  logic signed [33:0] cosv, opnd;
  logic [33:0] m_mag;
  logic [31:0] ang, tang;
  logic signed [33:0] dx, dy, at;
  logic [54:0] psum;
  logic [44:0] pq;
  logic signed [46:0] fval;
  logic [46:0] fmag;
  logic        f_small, f_pos, f_neg;
  logic signed [51:0] t1;
  logic signed [52:0] integral;
  logic [52:0] imag;
  logic [32:0] rem_sh;
  logic        qbit;
  logic [31:0] half_c;

  assign busy = (state != S_IDLE);

  // CORDIC operands and outputs
  always_comb begin
    ang   = (arg > PI_Q30) ? PI_Q30 : arg;
    tang  = (ang > HALF_PI_Q30) ? (PI_Q30 - ang) : ang;
    dx    = cy >>> ci;
    dy    = cx >>> ci;
    at    = $signed({2'b00, atan_q30(6'(ci))});
    cosv  = flip ? -cx : cx;
    opnd  = (phase == PH_AVG) ? cosv : cy;
    m_mag = opnd[33] ? 34'(-opnd) : 34'(opnd);
  end

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_MUL_AX: begin
        ma = $signed({10'd0, a_reg});
        mb = $signed({2'd0, arg});
      end
      S_MUL_HI: begin
        ma = $signed({14'd0, ax[39:20]});
        mb = $signed(m_mag);
      end
      S_MUL_LO: begin
        ma = $signed({14'd0, ax[19:0]});
        mb = $signed(m_mag);
      end
      S_T1: begin
        ma = $signed({9'd0, 25'(a_reg) + 25'd65536});
        mb = cy;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mul_p = ma * mb;
  end

  // function value, integral and divider step
  always_comb begin
    psum     = 55'(hm) + 55'(mul_p[52:20]);
    pq       = psum[54:10];
    fval     = 47'(cosv) + 47'(mq);
    fmag     = fval[46] ? 47'(-fval) : 47'(fval);
    f_small  = fmag < {15'd0, tolerance};
    f_pos    = !fval[46] && (fval != '0);
    f_neg    = fval[46];
    t1       = 52'(mul_p >>> 16);
    integral = 53'(t1) - 53'(mq);
    imag     = integral[52] ? 53'(-integral) : 53'(integral);
    rem_sh   = {rem[31:0], num[63]};
    qbit     = rem_sh >= {1'b0, root_r};
    half_c   = (interval_high - interval_low) >> 1;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance      <= TOL_RESET;
      max_iterations <= MAXIT_RESET;
    end else if (write_enable) begin
      unique case (write_index)
        REG_TOLERANCE: tolerance      <= write_data;
        REG_MAX_ITER:  max_iterations <= write_data[7:0];
        default:       tolerance      <= tolerance;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            a_reg         <= a_value;
            interval_low  <= '0;
            interval_high <= PI_Q30;
            midpoint      <= '0;
            step_count    <= '0;
            arg           <= '0;
            phase         <= PH_F0;
            state         <= S_PREP;
          end
        end
        S_PREP: begin
          cx    <= $signed({2'b00, GAIN_Q30});
          cy    <= '0;
          cz    <= $signed({2'b00, tang});
          flip  <= ang > HALF_PI_Q30;
          ci    <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          // one micro-rotation per cycle
          if (!cz[33]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - at;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + at;
          end
          if (ci == CW'(CORDIC_STEPS - 1)) begin
            state <= S_MUL_AX;
          end else begin
            ci <= ci + 1'b1;
          end
        end
        S_MUL_AX: begin
          ax    <= mul_p[55:16];
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          hm    <= mul_p[53:0];
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          mq    <= opnd[33] ? -$signed({1'b0, pq}) : $signed({1'b0, pq});
          state <= (phase == PH_AVG) ? S_T1 : S_FDONE;
        end
        S_FDONE: begin
          priority case (phase)
            PH_F0: begin
              low_pos <= f_pos;
              low_neg <= f_neg;
              if (f_small) begin
                root_r   <= '0;
                status_r <= ST_ENDPOINT;
                state    <= S_FINISH;
              end else begin
                arg   <= PI_Q30;
                phase <= PH_FPI;
                state <= S_PREP;
              end
            end
            PH_FPI: begin
              if (f_small) begin
                root_r   <= PI_Q30;
                status_r <= ST_ENDPOINT;
                state    <= S_FINISH;
              end else begin
                state <= S_STEP;
              end
            end
            default: begin
              step_count <= step_count + 8'd1;
              if (f_small || half < tolerance) begin
                root_r   <= midpoint;
                status_r <= ST_CONVERGED;
                state    <= S_FINISH;
              end else begin
                if ((low_pos && f_neg) || (low_neg && f_pos)) begin
                  interval_high <= midpoint;
                end else begin
                  interval_low <= midpoint;
                  low_pos      <= f_pos;
                  low_neg      <= f_neg;
                end
                state <= S_STEP;
              end
            end
          endcase
        end
        S_STEP: begin
          if (step_count < max_iterations) begin
            half     <= half_c;
            midpoint <= interval_low + half_c;
            arg      <= interval_low + half_c;
            phase    <= PH_FMID;
            state    <= S_PREP;
          end else begin
            root_r   <= midpoint;
            status_r <= ST_ITER_LIM;
            state    <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (root_r == '0) begin
            root    <= '0;
            average <= '0;
            status  <= ST_ZERO_ROOT;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            arg   <= root_r;
            phase <= PH_AVG;
            state <= S_PREP;
          end
        end
        S_T1: begin
          ineg  <= integral[52];
          num   <= {imag[47:0], 16'd0};
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          rem  <= qbit ? (rem_sh - {1'b0, root_r}) : rem_sh;
          num  <= {num[62:0], qbit};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd63) state <= S_SAT;
        end
        S_SAT: begin
          if (ineg) begin
            average <= (num > 64'h8000_0000) ? 32'sh8000_0000 : $signed(-num[31:0]);
          end else begin
            average <= (num > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(num[31:0]);
          end
          root   <= root_r;
          status <= status_r;
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_zero_status: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status == ST_ZERO_ROOT) == (root == '0)))
    else $error("zero-root status mismatch");
  a_root_range: assert property (@(posedge clk) disable iff (rst) done |-> root <= PI_Q30)
    else $error("root outside [0,pi]");
  a_interval: assert property (@(posedge clk) disable iff (rst)
    busy |-> interval_low <= interval_high)
    else $error("bisection interval inverted");
`endif

endmodule
